>>> rtl/vpc_pkg.sv
package vpc_pkg;

  // default sizes
  localparam int VALVE_COUNT_DEF  = 8;
  localparam int BLINK_PULSES_DEF = 3;

  // event kinds
  localparam logic [3:0] KIND_TICK    = 4'd0;
  localparam logic [3:0] KIND_UP      = 4'd1;
  localparam logic [3:0] KIND_DOWN    = 4'd2;
  localparam logic [3:0] KIND_TOGGLE  = 4'd3;
  localparam logic [3:0] KIND_SERVICE = 4'd4;
  localparam logic [3:0] KIND_STOP    = 4'd5;
  localparam logic [3:0] KIND_REPORT  = 4'd6;
  localparam logic [3:0] KIND_BLINK   = 4'd7;
  localparam logic [3:0] KIND_REFRESH = 4'd8;

  // register indexes
  localparam logic [2:0] REG_WATCHDOG   = 3'd0;
  localparam logic [2:0] REG_IDLE       = 3'd1;
  localparam logic [2:0] REG_BLINK      = 3'd2;
  localparam logic [2:0] REG_VALVE_MASK = 3'd3;
  localparam logic [2:0] REG_LED_MASK   = 3'd4;

  // register reset values
  localparam logic [26:0] WATCHDOG_RST = 27'(90000 * 1000);
  localparam logic [15:0] IDLE_RST     = 16'd30000;
  localparam logic [7:0]  BLINK_RST    = 8'd130;
  localparam logic [7:0]  MASK_RST     = 8'hFF;

  localparam logic [3:0] SEL_NONE = 4'd8;

  // status led pattern timing
  localparam logic [10:0] SVC_ON     = 11'd130;
  localparam logic [10:0] SVC_UNIT   = 11'd300;
  localparam logic [10:0] SVC_TRIPLE = 11'd900;
  localparam logic [10:0] SVC_CYCLE  = 11'd2000;
  localparam logic [7:0]  ERR_CYCLE  = 8'd250;
  localparam logic [7:0]  ERR_ON     = 8'd150;
  localparam logic [10:0] WARN_CYCLE = 11'd1500;
  localparam logic [10:0] WARN_ON    = 11'd250;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] valve_states;
    logic       app_error;
    logic       app_warning;
  } in_item_t;

  typedef struct packed {
    logic [7:0] valve_drive;
    logic [7:0] led_drive;
    logic       status_led;
    logic [3:0] selection;
    logic       service_active;
  } out_item_t;

  typedef struct packed {
    logic advance;
    logic service;
    logic error;
    logic warning;
  } status_req_t;

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_EXEC,
    ST_FUSE,
    ST_IDLET,
    ST_BLINK,
    ST_DONE
  } seq_state_t;

endpackage

>>> rtl/vpc_status.sv
module vpc_status
  import vpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  status_req_t req,
  output logic        level
);

  logic [7:0]  err_phase_r, err_phase_nxt;
  logic [10:0] warn_phase_r, warn_phase_nxt;
  logic [10:0] svc_phase_r, svc_phase_nxt;
  logic        svc_on;

  // free-running phase counters, one step per tick
  always_comb begin
    err_phase_nxt  = err_phase_r;
    warn_phase_nxt = warn_phase_r;
    svc_phase_nxt  = svc_phase_r;
    if (req.advance) begin
      err_phase_nxt  = (err_phase_r == ERR_CYCLE - 8'd1) ? '0 : err_phase_r + 8'd1;
      warn_phase_nxt = (warn_phase_r == WARN_CYCLE - 11'd1) ? '0 : warn_phase_r + 11'd1;
      svc_phase_nxt  = (svc_phase_r == SVC_CYCLE - 11'd1) ? '0 : svc_phase_r + 11'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_phase_r  <= '0;
      warn_phase_r <= '0;
      svc_phase_r  <= '0;
    end else begin
      err_phase_r  <= err_phase_nxt;
      warn_phase_r <= warn_phase_nxt;
      svc_phase_r  <= svc_phase_nxt;
    end
  end

  // three short pulses at the start of the service cycle
  assign svc_on = (svc_phase_r < SVC_ON)
               || (svc_phase_r >= SVC_UNIT && svc_phase_r < SVC_UNIT + SVC_ON)
               || (svc_phase_r >= 11'(2 * SVC_UNIT) && svc_phase_r < 11'(2 * SVC_UNIT) + SVC_ON);

  // service wins over error, error over warning
  always_comb begin
    if (req.service) begin
      level = svc_on && (svc_phase_r < SVC_TRIPLE);
    end else if (req.error) begin
      level = err_phase_r < ERR_ON;
    end else if (req.warning) begin
      level = warn_phase_r < WARN_ON;
    end else begin
      level = 1'b0;
    end
  end

endmodule

>>> rtl/valve_panel_controller.sv
// an accepted item passes through EXEC and DONE; a tick sweeps the fuses by index in
// FUSE, then IDLET and BLINK, before DONE; out_valid is registered as DONE is left,
// and DONE waits while the last result is held; a new item is taken only in WAIT, once
// the last has left DONE; the fuse, idle and blink timers share one down-counter
// reset: synchronous active-low rst_n clears panel state and out_valid, loads register defaults
module valve_panel_controller
  import vpc_pkg::*;
#(
  parameter int VALVE_COUNT  = VALVE_COUNT_DEF,
  parameter int BLINK_PULSES = BLINK_PULSES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = (VALVE_COUNT > 1) ? $clog2(VALVE_COUNT) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(VALVE_COUNT - 1);
  localparam logic [3:0]       VC4       = 4'(VALVE_COUNT);
  localparam logic [7:0]       VALVE_BITS = 8'((1 << VALVE_COUNT) - 1);
  localparam logic [3:0]       BLINK_END = 4'(2 * BLINK_PULSES);

  // configuration registers
  logic [26:0] wd_ms_r;
  logic [15:0] idle_ms_r;
  logic [7:0]  blink_ms_r;
  logic [7:0]  vpm_r, lpm_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wd_ms_r    <= WATCHDOG_RST;
      idle_ms_r  <= IDLE_RST;
      blink_ms_r <= BLINK_RST;
      vpm_r      <= MASK_RST;
      lpm_r      <= MASK_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_WATCHDOG:   wd_ms_r    <= pwdata[26:0];
        REG_IDLE:       idle_ms_r  <= pwdata[15:0];
        REG_BLINK:      blink_ms_r <= pwdata[7:0];
        REG_VALVE_MASK: vpm_r      <= pwdata[7:0];
        REG_LED_MASK:   lpm_r      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[4:2])
      REG_WATCHDOG:   prdata = {5'd0, wd_ms_r};
      REG_IDLE:       prdata = {16'd0, idle_ms_r};
      REG_BLINK:      prdata = {24'd0, blink_ms_r};
      REG_VALVE_MASK: prdata = {24'd0, vpm_r};
      REG_LED_MASK:   prdata = {24'd0, lpm_r};
      default:        prdata = '0;
    endcase
  end

  // panel state
  seq_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  in_item_t         item_r;
  logic [7:0]  open_r, open_nxt;
  logic [7:0]  led_r, led_nxt;
  logic [3:0]  sel_r, sel_nxt;
  logic        svc_r, svc_nxt;
  logic [26:0] fuse_left_r [VALVE_COUNT];
  logic [26:0] fuse_left_nxt [VALVE_COUNT];
  logic [VALVE_COUNT-1:0] fuse_armed_r, fuse_armed_nxt;
  logic [15:0] idle_left_r, idle_left_nxt;
  logic        idle_armed_r, idle_armed_nxt;
  logic [7:0]  blink_left_r, blink_left_nxt;
  logic        blink_armed_r, blink_armed_nxt;
  logic [2:0]  blink_phase_r, blink_phase_nxt;
  logic [2:0]  blink_target_r, blink_target_nxt;
  logic        blink_rest_r, blink_rest_nxt;
  logic        out_valid_r;
  out_item_t   out_r;
  logic        out_free;

  // shared down-counter: fires at one or zero
  logic [26:0] cd_in, cd_next;
  logic        cd_fire;

  always_comb begin
    unique case (state_r)
      ST_FUSE:  cd_in = fuse_left_r[idx_r];
      ST_IDLET: cd_in = {11'd0, idle_left_r};
      ST_BLINK: cd_in = {19'd0, blink_left_r};
      default:  cd_in = '0;
    endcase
  end

  assign cd_fire = cd_in <= 27'd1;
  assign cd_next = cd_fire ? '0 : cd_in - 27'd1;

  // status led unit
  status_req_t st_req;
  logic        st_level;

  assign st_req.advance = (state_r == ST_EXEC) && (item_r.kind == KIND_TICK);
  assign st_req.service = svc_r;
  assign st_req.error   = item_r.app_error;
  assign st_req.warning = item_r.app_warning;

  vpc_status u_status (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (st_req),
    .level (st_level)
  );

  assign in_ready = (state_r == ST_WAIT);
  assign out_free = !out_valid_r || out_ready;

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_WAIT: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        idx_nxt   = '0;
        state_nxt = (item_r.kind == KIND_TICK) ? ST_FUSE : ST_DONE;
      end
      ST_FUSE: begin
        if (idx_r == IDX_LAST) begin
          state_nxt = ST_IDLET;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_IDLET: state_nxt = ST_BLINK;
      ST_BLINK: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_WAIT;
      end
      default: state_nxt = ST_WAIT;
    endcase
  end

  // datapath updates per step
  always_comb begin
    logic [7:0] o_new;
    logic       do_sync;
    logic       sel_ok;
    logic [2:0] s;
    logic       on;

    open_nxt         = open_r;
    led_nxt          = led_r;
    sel_nxt          = sel_r;
    svc_nxt          = svc_r;
    fuse_left_nxt    = fuse_left_r;
    fuse_armed_nxt   = fuse_armed_r;
    idle_left_nxt    = idle_left_r;
    idle_armed_nxt   = idle_armed_r;
    blink_left_nxt   = blink_left_r;
    blink_armed_nxt  = blink_armed_r;
    blink_phase_nxt  = blink_phase_r;
    blink_target_nxt = blink_target_r;
    blink_rest_nxt   = blink_rest_r;
    do_sync = 1'b0;
    sel_ok  = sel_r < VC4;
    o_new   = item_r.valve_states & vpm_r & VALVE_BITS;
    s       = sel_ok ? sel_r[2:0] : 3'd0;
    on      = 1'b0;

    unique case (state_r)
      ST_EXEC: begin
        case (item_r.kind)
          KIND_UP: begin
            if (!svc_r) begin
              idle_armed_nxt = 1'b1;
              idle_left_nxt  = idle_ms_r;
              if (!sel_ok || sel_r + 4'd1 >= VC4) sel_nxt = 4'd0;
              else sel_nxt = sel_r + 4'd1;
            end
          end
          KIND_DOWN: begin
            if (!svc_r) begin
              idle_armed_nxt = 1'b1;
              idle_left_nxt  = idle_ms_r;
              if (!sel_ok || sel_r == 4'd0) sel_nxt = VC4 - 4'd1;
              else sel_nxt = sel_r - 4'd1;
            end
          end
          KIND_TOGGLE: begin
            if (!svc_r) begin
              idle_armed_nxt = 1'b1;
              idle_left_nxt  = idle_ms_r;
              open_nxt       = open_r ^ (8'd1 << s);
              led_nxt        = open_nxt;
              do_sync        = 1'b1;
            end
          end
          KIND_SERVICE: begin
            idle_armed_nxt = 1'b1;
            idle_left_nxt  = idle_ms_r;
            svc_nxt        = !svc_r;
          end
          KIND_STOP: begin
            blink_armed_nxt = 1'b0;
            idle_armed_nxt  = 1'b0;
            fuse_armed_nxt  = '0;
            open_nxt        = '0;
            sel_nxt         = 4'd0;
            led_nxt         = '0;
          end
          KIND_REPORT: begin
            if (svc_r && o_new != 8'd0) begin
              open_nxt       = '0;
              fuse_armed_nxt = '0;
            end else begin
              open_nxt = o_new;
              do_sync  = 1'b1;
            end
            led_nxt = open_nxt;
          end
          KIND_BLINK: begin
            blink_armed_nxt = 1'b0;
            if (sel_ok && lpm_r[sel_r[2:0]]) begin
              // first phase drives the led away from its resting level
              blink_target_nxt = sel_r[2:0];
              blink_rest_nxt   = open_r[sel_r[2:0]];
              led_nxt[sel_r[2:0]] = !open_r[sel_r[2:0]];
              blink_phase_nxt  = 3'd1;
              blink_armed_nxt  = 1'b1;
              blink_left_nxt   = blink_ms_r;
            end
          end
          KIND_REFRESH: begin
            open_nxt = o_new;
            led_nxt  = o_new;
          end
          default: ;
        endcase
      end
      ST_FUSE: begin
        if (fuse_armed_r[idx_r]) begin
          fuse_left_nxt[idx_r] = cd_next;
          if (cd_fire) begin
            fuse_armed_nxt[idx_r] = 1'b0;
            if (open_r[idx_r]) begin
              open_nxt[idx_r] = 1'b0;
              led_nxt         = open_nxt;
            end
          end
        end
      end
      ST_IDLET: begin
        if (idle_armed_r) begin
          idle_left_nxt = cd_next[15:0];
          if (cd_fire) begin
            idle_armed_nxt = 1'b0;
            sel_nxt        = SEL_NONE;
          end
        end
      end
      ST_BLINK: begin
        if (blink_armed_r) begin
          blink_left_nxt = cd_next[7:0];
          if (cd_fire) begin
            blink_armed_nxt = 1'b0;
            if ({1'b0, blink_target_r} >= VC4 || !lpm_r[blink_target_r]
                || {1'b0, blink_phase_r} >= BLINK_END) begin
              led_nxt = open_r;
            end else begin
              // even phases drive opposite to rest, odd phases restore
              on = blink_phase_r[0] ? blink_rest_r : !blink_rest_r;
              led_nxt[blink_target_r] = on;
              blink_phase_nxt = blink_phase_r + 3'd1;
              blink_armed_nxt = 1'b1;
              blink_left_nxt  = blink_ms_r;
            end
          end
        end
      end
      default: ;
    endcase

    // fuses follow opened and closed valves
    if (do_sync) begin
      for (int i = 0; i < VALVE_COUNT; i++) begin
        if (open_r[i] && !open_nxt[i]) fuse_armed_nxt[i] = 1'b0;
        if (!open_r[i] && open_nxt[i]) begin
          fuse_armed_nxt[i] = 1'b1;
          fuse_left_nxt[i]  = wd_ms_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_WAIT;
      idx_r          <= '0;
      open_r         <= '0;
      led_r          <= '0;
      sel_r          <= SEL_NONE;
      svc_r          <= 1'b0;
      fuse_armed_r   <= '0;
      idle_left_r    <= '0;
      idle_armed_r   <= 1'b0;
      blink_left_r   <= '0;
      blink_armed_r  <= 1'b0;
      blink_phase_r  <= '0;
      blink_target_r <= '0;
      blink_rest_r   <= 1'b0;
      for (int i = 0; i < VALVE_COUNT; i++) fuse_left_r[i] <= '0;
    end else begin
      state_r        <= state_nxt;
      idx_r          <= idx_nxt;
      open_r         <= open_nxt;
      led_r          <= led_nxt;
      sel_r          <= sel_nxt;
      svc_r          <= svc_nxt;
      fuse_armed_r   <= fuse_armed_nxt;
      idle_left_r    <= idle_left_nxt;
      idle_armed_r   <= idle_armed_nxt;
      blink_left_r   <= blink_left_nxt;
      blink_armed_r  <= blink_armed_nxt;
      blink_phase_r  <= blink_phase_nxt;
      blink_target_r <= blink_target_nxt;
      blink_rest_r   <= blink_rest_nxt;
      fuse_left_r    <= fuse_left_nxt;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= in_data;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_r.valve_drive    <= open_r & vpm_r;
      out_r.led_drive      <= led_r & lpm_r;
      out_r.status_led     <= st_level;
      out_r.selection      <= sel_r;
      out_r.service_active <= svc_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_sweep_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FUSE |=> (state_r == ST_FUSE && idx_r == $past(idx_r) + IDX_W'(1))
                           || state_r == ST_IDLET)
    else $error("fuse sweep skipped or repeated an entry");

  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r <= SEL_NONE)
    else $error("selection out of range");

  a_open_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (open_r & ~VALVE_BITS) == 8'd0)
    else $error("open mask has bits beyond fitted valve count");

  a_blink_phase: assert property (@(posedge clk) disable iff (!rst_n)
    blink_armed_r |-> (blink_phase_r != 3'd0 && {1'b0, blink_phase_r} <= BLINK_END))
    else $error("blink armed with bad phase");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> out_valid_r && state_r == ST_WAIT)
    else $error("finished item did not produce a result");
`endif

endmodule

>>> tb/tb_valve_panel_controller.sv
module tb_valve_panel_controller
  import vpc_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 400;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  valve_panel_controller dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // stimulus and expected results
  in_item_t  pending_events[$];
  out_item_t expected_panel[$];
  int        send_idle_pct;
  int        recv_stall_pct;
  bit        hold_request;
  bit        failed;

  // shadow configuration
  logic [26:0] cfg_watchdog;
  logic [15:0] cfg_idle;
  logic [7:0]  cfg_blink;
  logic [7:0]  cfg_valve_mask;
  logic [7:0]  cfg_led_mask;

  // shadow panel state
  logic [7:0]  open_mask;
  logic [7:0]  led_latch;
  logic [3:0]  sel_valve;
  logic        svc_flag;
  logic [26:0] fuse_left [8];
  logic        fuse_armed [8];
  logic [15:0] idle_left;
  logic        idle_armed;
  logic [7:0]  blink_left;
  logic        blink_armed;
  logic [2:0]  blink_phase;
  logic [2:0]  blink_target;
  logic        blink_rest;
  logic [7:0]  err_phase;
  logic [10:0] warn_phase;
  logic [10:0] svc_phase;

  task automatic panel_reset();
    cfg_watchdog   = WATCHDOG_RST;
    cfg_idle       = IDLE_RST;
    cfg_blink      = BLINK_RST;
    cfg_valve_mask = MASK_RST;
    cfg_led_mask   = MASK_RST;
    open_mask = '0; led_latch = '0; sel_valve = SEL_NONE; svc_flag = 1'b0;
    for (int i = 0; i < 8; i++) begin
      fuse_left[i] = '0;
      fuse_armed[i] = 1'b0;
    end
    idle_left = '0; idle_armed = 1'b0;
    blink_left = '0; blink_armed = 1'b0;
    blink_phase = '0; blink_target = '0; blink_rest = 1'b0;
    err_phase = '0; warn_phase = '0; svc_phase = '0;
  endtask

  // arm fuses on newly opened valves, disarm on closed ones
  task automatic fuses_track(input logic [7:0] prev, input logic [7:0] now);
    for (int i = 0; i < 8; i++) begin
      if (prev[i] && !now[i]) fuse_armed[i] = 1'b0;
      if (!prev[i] && now[i]) begin
        fuse_armed[i] = 1'b1;
        fuse_left[i] = cfg_watchdog;
      end
    end
  endtask

  task automatic blink_advance();
    logic lit;
    if (!cfg_led_mask[blink_target] || blink_phase >= 3'(2 * BLINK_PULSES_DEF)) begin
      led_latch = open_mask;
      return;
    end
    lit = blink_phase[0] ? blink_rest : !blink_rest;
    led_latch[blink_target] = lit;
    blink_phase = blink_phase + 3'd1;
    blink_armed = 1'b1;
    blink_left = cfg_blink;
  endtask

  task automatic one_ms();
    err_phase  = (err_phase == ERR_CYCLE - 1) ? '0 : err_phase + 8'd1;
    warn_phase = (warn_phase == WARN_CYCLE - 1) ? '0 : warn_phase + 11'd1;
    svc_phase  = (svc_phase == SVC_CYCLE - 1) ? '0 : svc_phase + 11'd1;
    // fuses by index, then idle, then blink
    for (int i = 0; i < 8; i++) begin
      if (fuse_armed[i]) begin
        if (fuse_left[i] <= 1) begin
          fuse_left[i] = '0;
          fuse_armed[i] = 1'b0;
          if (open_mask[i]) begin
            open_mask[i] = 1'b0;
            led_latch = open_mask;
          end
        end else begin
          fuse_left[i] = fuse_left[i] - 27'd1;
        end
      end
    end
    if (idle_armed) begin
      if (idle_left <= 1) begin
        idle_left = '0;
        idle_armed = 1'b0;
        sel_valve = SEL_NONE;
      end else begin
        idle_left = idle_left - 16'd1;
      end
    end
    if (blink_armed) begin
      if (blink_left <= 1) begin
        blink_left = '0;
        blink_armed = 1'b0;
        blink_advance();
      end else begin
        blink_left = blink_left - 8'd1;
      end
    end
  endtask

  task automatic panel_event(input in_item_t ev);
    logic [7:0] prev;
    logic [2:0] s;
    out_item_t  r;
    case (ev.kind)
      KIND_TICK: one_ms();
      KIND_UP: if (!svc_flag) begin
        idle_armed = 1'b1; idle_left = cfg_idle;
        sel_valve = (sel_valve >= SEL_NONE || sel_valve == 4'd7) ? 4'd0 : sel_valve + 4'd1;
      end
      KIND_DOWN: if (!svc_flag) begin
        idle_armed = 1'b1; idle_left = cfg_idle;
        sel_valve = (sel_valve >= SEL_NONE || sel_valve == 4'd0) ? 4'd7 : sel_valve - 4'd1;
      end
      KIND_TOGGLE: if (!svc_flag) begin
        idle_armed = 1'b1; idle_left = cfg_idle;
        prev = open_mask;
        s = (sel_valve < SEL_NONE) ? sel_valve[2:0] : 3'd0;
        open_mask[s] = !open_mask[s];
        fuses_track(prev, open_mask);
        led_latch = open_mask;
      end
      KIND_SERVICE: begin
        idle_armed = 1'b1; idle_left = cfg_idle;
        svc_flag = !svc_flag;
      end
      KIND_STOP: begin
        blink_armed = 1'b0;
        idle_armed = 1'b0;
        for (int i = 0; i < 8; i++) fuse_armed[i] = 1'b0;
        open_mask = '0;
        sel_valve = 4'd0;
        led_latch = open_mask;
      end
      KIND_REPORT: begin
        prev = open_mask;
        open_mask = ev.valve_states & cfg_valve_mask;
        if (svc_flag && open_mask != 0) begin
          open_mask = '0;
          for (int i = 0; i < 8; i++) fuse_armed[i] = 1'b0;
        end else begin
          fuses_track(prev, open_mask);
        end
        led_latch = open_mask;
      end
      KIND_BLINK: begin
        blink_armed = 1'b0;
        if (sel_valve < SEL_NONE && cfg_led_mask[sel_valve[2:0]]) begin
          blink_target = sel_valve[2:0];
          blink_rest = open_mask[sel_valve[2:0]];
          blink_phase = '0;
          blink_advance();
        end
      end
      KIND_REFRESH: begin
        open_mask = ev.valve_states & cfg_valve_mask;
        led_latch = open_mask;
      end
      default: ;
    endcase
    r.valve_drive = open_mask & cfg_valve_mask;
    r.led_drive = led_latch & cfg_led_mask;
    if (svc_flag) r.status_led = (svc_phase < SVC_TRIPLE) && ((svc_phase % SVC_UNIT) < SVC_ON);
    else if (ev.app_error) r.status_led = err_phase < ERR_ON;
    else if (ev.app_warning) r.status_led = warn_phase < WARN_ON;
    else r.status_led = 1'b0;
    r.selection = sel_valve;
    r.service_active = svc_flag;
    expected_panel.push_back(r);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // input driver: accepted transfers feed the predictor
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) panel_event(in_data);
      if (!in_valid || in_ready) begin
        if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_events.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver with random stalls and one long hold-off on request
  int hold_count;
  always @(posedge clk) begin
    if (hold_request && hold_count == 0) hold_count = LONG_HOLD;
    if (hold_count > 0) begin
      hold_count = hold_count - 1;
      if (hold_count == 0) hold_request = 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_panel.size() == 0) begin
        $error("unexpected result transfer %h", out_data);
        failed = 1'b1;
      end else begin
        want = expected_panel.pop_front();
        if (out_data.valve_drive !== want.valve_drive) begin
          $error("valve_drive expected %h got %h", want.valve_drive, out_data.valve_drive);
          failed = 1'b1;
        end
        if (out_data.led_drive !== want.led_drive) begin
          $error("led_drive expected %h got %h", want.led_drive, out_data.led_drive);
          failed = 1'b1;
        end
        if (out_data.status_led !== want.status_led) begin
          $error("status_led expected %b got %b", want.status_led, out_data.status_led);
          failed = 1'b1;
        end
        if (out_data.selection !== want.selection) begin
          $error("selection expected %0d got %0d", want.selection, out_data.selection);
          failed = 1'b1;
        end
        if (out_data.service_active !== want.service_active) begin
          $error("service_active expected %b got %b", want.service_active,
                 out_data.service_active);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  int quiet_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("valve_panel_controller verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_WATCHDOG:   cfg_watchdog = value[26:0];
      REG_IDLE:       cfg_idle = value[15:0];
      REG_BLINK:      cfg_blink = value[7:0];
      REG_VALVE_MASK: cfg_valve_mask = value[7:0];
      REG_LED_MASK:   cfg_led_mask = value[7:0];
      default: ;
    endcase
  endtask

  // wait until all queued events are taken and every result is back
  task automatic drain();
    while (pending_events.size() > 0 || in_valid || expected_panel.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic in_item_t make_event(input logic [3:0] kind, input logic [7:0] states);
    in_item_t ev;
    ev.kind = kind;
    ev.valve_states = states;
    ev.app_error = 1'($urandom_range(1));
    ev.app_warning = 1'($urandom_range(1));
    return ev;
  endfunction

  function automatic in_item_t random_event();
    int r;
    logic [3:0] kind;
    r = $urandom_range(99);
    if (r < 50) kind = KIND_TICK;
    else if (r < 55) kind = KIND_UP;
    else if (r < 60) kind = KIND_DOWN;
    else if (r < 68) kind = KIND_TOGGLE;
    else if (r < 71) kind = KIND_SERVICE;
    else if (r < 73) kind = KIND_STOP;
    else if (r < 80) kind = KIND_REPORT;
    else if (r < 87) kind = KIND_BLINK;
    else if (r < 96) kind = KIND_REFRESH;
    else kind = 4'($urandom_range(15, 9));
    return make_event(kind, 8'($urandom));
  endfunction

  // main sequence
  initial begin
    logic [26:0] wd;
    logic [15:0] idl;
    logic [7:0]  blk, vm, lm;
    rst_n = 1'b0;
    in_valid = 1'b0; in_data = '0; out_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_request = 1'b0; failed = 1'b0;
    hold_count = 0;
    panel_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: buttons, selection wrap, service lockout, stop, reports, blink
    pending_events.push_back(make_event(KIND_TOGGLE, 8'h00));
    pending_events.push_back(make_event(KIND_TICK, 8'hFF));
    pending_events.push_back(make_event(KIND_DOWN, 8'h00));
    pending_events.push_back(make_event(KIND_UP, 8'hFF));
    pending_events.push_back(make_event(KIND_TOGGLE, 8'h00));
    pending_events.push_back(make_event(KIND_BLINK, 8'h00));
    pending_events.push_back(make_event(KIND_TICK, 8'h00));
    pending_events.push_back(make_event(KIND_REPORT, 8'hFF));
    pending_events.push_back(make_event(KIND_REPORT, 8'h00));
    pending_events.push_back(make_event(KIND_REFRESH, 8'hFF));
    pending_events.push_back(make_event(KIND_SERVICE, 8'h00));
    pending_events.push_back(make_event(KIND_UP, 8'h00));
    pending_events.push_back(make_event(KIND_TOGGLE, 8'h00));
    pending_events.push_back(make_event(KIND_REPORT, 8'hA5));
    pending_events.push_back(make_event(KIND_REPORT, 8'h00));
    pending_events.push_back(make_event(KIND_SERVICE, 8'h00));
    pending_events.push_back(make_event(KIND_STOP, 8'hFF));
    pending_events.push_back(make_event(KIND_BLINK, 8'h00));
    pending_events.push_back(make_event(4'd9, 8'h5A));
    pending_events.push_back(make_event(4'd15, 8'hFF));
    pending_events.push_back(make_event(KIND_REFRESH, 8'h00));
    drain();

    // random phases across settings and idling modes
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin wd = 27'd1; idl = 16'd1; blk = 8'd1; vm = 8'hFF; lm = 8'hFF; end
        1: begin wd = 27'h7FFFFFF; idl = 16'hFFFF; blk = 8'hFF; vm = 8'h00; lm = 8'h00; end
        2: begin wd = 27'd20; idl = 16'd40; blk = 8'd3; vm = 8'hFF; lm = 8'hFF; end
        3: begin wd = 27'd7; idl = 16'd15; blk = 8'd1; vm = 8'hA5; lm = 8'h5A; end
        default: begin
          wd = 27'($urandom_range(60, 1)); idl = 16'($urandom_range(80, 1));
          blk = 8'($urandom_range(6, 1)); vm = 8'($urandom); lm = 8'($urandom);
        end
      endcase
      reg_write(REG_WATCHDOG, 32'(wd));
      reg_write(REG_IDLE, 32'(idl));
      reg_write(REG_BLINK, 32'(blk));
      reg_write(REG_VALVE_MASK, 32'(vm));
      reg_write(REG_LED_MASK, 32'(lm));
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 76; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 76; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      for (int k = 0; k < 155; k++) pending_events.push_back(random_event());
      if (p == 4) hold_request = 1'b1;
      drain();
    end

    send_idle_pct = 0; recv_stall_pct = 0;
    drain();
    if (!failed) begin
      $display("valve_panel_controller verification clean");
    end else begin
      $display("valve_panel_controller verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/vpc_pkg.sv
rtl/vpc_status.sv
rtl/valve_panel_controller.sv
tb/tb_valve_panel_controller.sv
